// ===== hw/rtl/json_message_framer_unit_defines.svh =====
// Assertion macros used by the checker file of the JSON message framer.
`ifndef JSON_MESSAGE_FRAMER_UNIT_DEFINES_SVH
`define JSON_MESSAGE_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define JMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define JMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// ===== hw/rtl/jmf_pkg.sv =====
// Types and character constants of the JSON message framer.
package jmf_pkg;

  typedef enum logic [1:0] {
    MODE_CHAR    = 2'd0,
    MODE_FLUSH   = 2'd1,
    MODE_DISCARD = 2'd2
  } jmf_mode_e;

  typedef enum logic [2:0] {
    END_NONE     = 3'd0,
    END_BALANCED = 3'd1,
    END_ERROR    = 3'd2,
    END_FLUSH    = 3'd3,
    END_DISCARD  = 3'd4
  } jmf_end_e;

  typedef enum logic [3:0] {
    PH_TOP    = 4'b0001,
    PH_STRUCT = 4'b0010,
    PH_STRING = 4'b0100,
    PH_ESCAPE = 4'b1000
  } jmf_phase_e;

  // Shift command broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } jmf_stack_cmd_t;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

// ===== hw/rtl/json_message_framer_unit.sv =====
// Top level of the JSON message framer: phase tracking, cell stack and output register.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i / in_stall_o  mode_i, char_in_i
//   result    out        out_valid_o / out_stall_i char_out_o, char_valid_o, last_o, end_kind_o
//
// A request is taken each cycle unless stalled; any result enters the output register.
// The cycle is bounded by the phase update and a single push or pop of the cell chain.
// Reset clears phase, fill count, open flag and output valid, not the payload or stack cells.
// While the output register is full and stalled, the input is stalled in the same cycle.
module json_message_framer_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       last_o,
  output logic [2:0] end_kind_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  jmf_pkg::jmf_phase_e     phase_d, phase_q;
  logic [CntW-1:0]         count_d, count_q;
  logic                    open_d, open_q;
  jmf_pkg::jmf_stack_cmd_t stack_cmd;
  logic [STACK_DEPTH-1:0]  cell_kind;
  logic                    new_kind;
  logic                    in_acc;
  logic                    full;
  logic                    is_open_ch, is_close_ch;

  logic                    res_valid;
  logic [7:0]              res_char;
  logic                    res_cv;
  jmf_pkg::jmf_end_e       res_end;

  logic                    out_valid_d, out_valid_q;
  logic [7:0]              char_q;
  logic                    cv_q;
  jmf_pkg::jmf_end_e       end_q;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign full        = (count_q == CntW'(STACK_DEPTH));
  assign new_kind    = (char_in_i == jmf_pkg::CH_LBRACKET);
  assign is_open_ch  = (char_in_i == jmf_pkg::CH_LBRACE) || (char_in_i == jmf_pkg::CH_LBRACKET);
  assign is_close_ch = (char_in_i == jmf_pkg::CH_RBRACE) || (char_in_i == jmf_pkg::CH_RBRACKET);

  // Cell 0 is the top of the stack.
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic above, below;
    if (g == 0) begin : g_head
      assign above = new_kind;
    end else begin : g_body
      assign above = cell_kind[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_tail
      assign below = 1'b0;
    end else begin : g_inner
      assign below = cell_kind[g+1];
    end
    jmf_stack_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (stack_cmd),
      .above_i (above),
      .below_i (below),
      .kind_o  (cell_kind[g])
    );
  end

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    open_d    = open_q;
    stack_cmd = '0;
    res_valid = 1'b0;
    res_char  = char_in_i;
    res_cv    = 1'b1;
    res_end   = jmf_pkg::END_NONE;
    if (in_acc) begin
      unique case (mode_i)
        jmf_pkg::MODE_CHAR: begin
          open_d    = 1'b1;
          res_valid = 1'b1;
          unique case (phase_q)
            jmf_pkg::PH_TOP: begin
              if (is_open_ch) begin
                phase_d = jmf_pkg::PH_STRUCT;
                if (full) begin
                  res_end = jmf_pkg::END_ERROR;
                end else begin
                  stack_cmd.push = 1'b1;
                  count_d        = count_q + CntW'(1);
                end
              end else if (!jmf_pkg::is_space(char_in_i)) begin
                res_end = jmf_pkg::END_ERROR;
              end
            end
            jmf_pkg::PH_STRUCT: begin
              if (char_in_i == jmf_pkg::CH_QUOTE) begin
                phase_d = jmf_pkg::PH_STRING;
              end else if (is_open_ch) begin
                if (full) begin
                  res_end = jmf_pkg::END_ERROR;
                end else begin
                  stack_cmd.push = 1'b1;
                  count_d        = count_q + CntW'(1);
                end
              end else if (is_close_ch) begin
                if (count_q == '0) begin
                  res_end = jmf_pkg::END_ERROR;
                end else begin
                  stack_cmd.pop = 1'b1;
                  count_d       = count_q - CntW'(1);
                  // The top cell says which closer is due: bracket or brace.
                  if (cell_kind[0] != (char_in_i == jmf_pkg::CH_RBRACKET)) begin
                    res_end = jmf_pkg::END_ERROR;
                  end else if (count_q == CntW'(1)) begin
                    res_end = jmf_pkg::END_BALANCED;
                  end
                end
              end
            end
            jmf_pkg::PH_STRING: begin
              if (char_in_i == jmf_pkg::CH_QUOTE) begin
                phase_d = jmf_pkg::PH_STRUCT;
              end else if (char_in_i == jmf_pkg::CH_BSLASH) begin
                phase_d = jmf_pkg::PH_ESCAPE;
              end
            end
            jmf_pkg::PH_ESCAPE: begin
              phase_d = jmf_pkg::PH_STRING;
            end
            default: begin
              phase_d = jmf_pkg::PH_TOP;
            end
          endcase
          if (res_end != jmf_pkg::END_NONE) begin
            phase_d = jmf_pkg::PH_TOP;
            count_d = '0;
            open_d  = 1'b0;
          end
        end
        jmf_pkg::MODE_FLUSH, jmf_pkg::MODE_DISCARD: begin
          phase_d   = jmf_pkg::PH_TOP;
          count_d   = '0;
          open_d    = 1'b0;
          res_valid = open_q;
          res_char  = '0;
          res_cv    = 1'b0;
          res_end   = (mode_i == jmf_pkg::MODE_FLUSH) ? jmf_pkg::END_FLUSH
                                                      : jmf_pkg::END_DISCARD;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= jmf_pkg::PH_TOP;
      count_q     <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      char_q <= res_char;
      cv_q   <= res_cv;
      end_q  <= res_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_out_o   = char_q;
  assign char_valid_o = cv_q;
  assign last_o       = (end_q != jmf_pkg::END_NONE);
  assign end_kind_o   = end_q;

endmodule

// ===== hw/rtl/jmf_stack_cell.sv =====
// One cell of the shifting bracket stack: holds one opener kind.
module jmf_stack_cell (
  input  logic                    clk_i,
  input  jmf_pkg::jmf_stack_cmd_t cmd_i,
  input  logic                    above_i,
  input  logic                    below_i,
  output logic                    kind_o
);

  logic kind_d, kind_q;

  // A push moves every entry one cell deeper; a pop moves them one cell up.
  always_comb begin
    kind_d = kind_q;
    if (cmd_i.push) begin
      kind_d = above_i;
    end else if (cmd_i.pop) begin
      kind_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

// ===== hw/rtl/jmf_checker.sv =====
// Port-level checker of the JSON message framer, bound to the top level.
`include "json_message_framer_unit_defines.svh"

module jmf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] mode_i,
  input logic [7:0] char_in_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       char_valid_o,
  input logic       last_o,
  input logic [2:0] end_kind_o
);

  // A stalled result keeps its valid and payload.
  `JMF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(char_out_o) && $stable(end_kind_o) && $stable(char_valid_o))

  // Every character request yields a result in the following cycle.
  `JMF_ASSERT_NEXT(a_char_result, in_valid_i && !in_stall_o && (mode_i == jmf_pkg::MODE_CHAR), out_valid_o)

  // The end mark and the end kind agree.
  `JMF_ASSERT_IMPL(a_last_kind, out_valid_o, last_o == (end_kind_o != jmf_pkg::END_NONE))

  // Results without a byte are always flush or discard ends with a zero byte.
  `JMF_ASSERT_IMPL(a_nochar_end, out_valid_o && !char_valid_o, (char_out_o == 8'd0) && ((end_kind_o == jmf_pkg::END_FLUSH) || (end_kind_o == jmf_pkg::END_DISCARD)))

endmodule

bind json_message_framer_unit jmf_checker u_jmf_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the JSON message framer: directed table, then random message streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jmf_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int RESET_CYCLES = 11;
  localparam int PHASE_ITEMS  = 180;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    jmf_end_e   kind;
  } frame_res_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
  } framer_req_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
    logic       typed;
    logic       has_res;
    frame_res_t res;
  } dir_row_t;

  localparam frame_res_t NO_RES = '0;

  // Rows with typed set carry their expectation here; the rest are predicted.
  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{MODE_CHAR,    CH_SPACE,    1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b0, END_NONE}},
    '{MODE_CHAR,    CH_LBRACE,   1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_QUOTE,    1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_BSLASH,   1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_QUOTE,    1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    8'hFF,       1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_QUOTE,    1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_LBRACKET, 1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    8'h00,       1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_RBRACKET, 1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_RBRACE,   1'b1, 1'b1, '{CH_RBRACE, 1'b1, 1'b1, END_BALANCED}},
    '{MODE_CHAR,    8'h78,       1'b1, 1'b1, '{8'h78, 1'b1, 1'b1, END_ERROR}},
    '{MODE_FLUSH,   8'h00,       1'b1, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_LBRACKET, 1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_RBRACE,   1'b1, 1'b1, '{CH_RBRACE, 1'b1, 1'b1, END_ERROR}},
    '{MODE_CHAR,    CH_TAB,      1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_LF,       1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_CR,       1'b0, 1'b0, NO_RES},
    '{MODE_CHAR,    CH_LBRACE,   1'b0, 1'b0, NO_RES},
    '{MODE_FLUSH,   8'hFF,       1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, END_FLUSH}},
    '{MODE_CHAR,    CH_LBRACKET, 1'b0, 1'b0, NO_RES},
    '{MODE_DISCARD, 8'h00,       1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, END_DISCARD}},
    '{MODE_DISCARD, 8'h00,       1'b1, 1'b0, NO_RES},
    '{MODE_UNKNOWN, 8'hFF,       1'b1, 1'b0, NO_RES},
    '{MODE_CHAR,    8'h00,       1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, END_ERROR}},
    '{MODE_CHAR,    8'hFF,       1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, END_ERROR}}
  };

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] mode_i       = MODE_CHAR;
  logic [7:0] char_in_i    = 8'h00;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] char_out_o;
  logic       char_valid_o;
  logic       last_o;
  logic [2:0] end_kind_o;

  // Predictor state.
  jmf_phase_e             pr_phase;
  bit [STACK_DEPTH-1:0]   pr_kinds;
  int                     pr_depth;
  bit                     pr_open;

  frame_res_t  frame_q [$];
  framer_req_t req_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int holds_asked;
  int holds_done;
  int hold_left;
  int fail_count;

  always #1 clk_i = ~clk_i;

  json_message_framer_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .char_valid_o(char_valid_o),
    .last_o      (last_o),
    .end_kind_o  (end_kind_o)
  );

  function automatic void framer_clear();
    pr_phase = PH_TOP;
    pr_kinds = '0;
    pr_depth = 0;
    pr_open  = 1'b0;
  endfunction

  function automatic bit is_opener(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_LBRACKET);
  endfunction

  function automatic bit push_opener(input logic [7:0] c);
    if (pr_depth >= STACK_DEPTH) return 1'b0;
    pr_kinds[pr_depth] = (c == CH_LBRACKET);
    pr_depth++;
    return 1'b1;
  endfunction

  function automatic jmf_end_e scan_byte(input logic [7:0] c);
    bit top_bracket;
    case (pr_phase)
      PH_TOP: begin
        if (is_opener(c)) begin
          pr_phase = PH_STRUCT;
          return push_opener(c) ? END_NONE : END_ERROR;
        end
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return END_NONE;
        return END_ERROR;
      end
      PH_STRUCT: begin
        if (c == CH_QUOTE) begin
          pr_phase = PH_STRING;
        end else if (is_opener(c)) begin
          if (!push_opener(c)) return END_ERROR;
        end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
          if (pr_depth == 0) return END_ERROR;
          pr_depth--;
          top_bracket = pr_kinds[pr_depth];
          if (top_bracket != (c == CH_RBRACKET)) return END_ERROR;
          if (pr_depth == 0) return END_BALANCED;
        end
        return END_NONE;
      end
      PH_STRING: begin
        if (c == CH_QUOTE) pr_phase = PH_STRUCT;
        else if (c == CH_BSLASH) pr_phase = PH_ESCAPE;
        return END_NONE;
      end
      default: begin
        pr_phase = PH_STRING;
        return END_NONE;
      end
    endcase
  endfunction

  // Advances the predictor by one request; returns 1 when a result is due.
  function automatic bit frame_step(input logic [1:0] mode, input logic [7:0] c,
                                    output frame_res_t res);
    jmf_end_e kind;
    bit had;
    res = NO_RES;
    if (mode == MODE_CHAR) begin
      pr_open = 1'b1;
      kind = scan_byte(c);
      res.ch       = c;
      res.ch_valid = 1'b1;
      res.last     = (kind != END_NONE);
      res.kind     = kind;
      if (kind != END_NONE) framer_clear();
      return 1'b1;
    end
    if (mode == MODE_FLUSH || mode == MODE_DISCARD) begin
      had = pr_open;
      framer_clear();
      res.last = 1'b1;
      if (mode == MODE_FLUSH) res.kind = END_FLUSH;
      else res.kind = END_DISCARD;
      return had;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] opener_for(input bit bracket);
    return bracket ? CH_LBRACKET : CH_LBRACE;
  endfunction

  function automatic logic [7:0] closer_for(input bit bracket);
    return bracket ? CH_RBRACKET : CH_RBRACE;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 7))
      0: return CH_LBRACE;
      1: return CH_LBRACKET;
      2: return CH_RBRACE;
      3: return CH_RBRACKET;
      4: return CH_QUOTE;
      5: return CH_BSLASH;
      6: return blank_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Any byte that does not change the structure phase.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_opener(c) || c == CH_RBRACE || c == CH_RBRACKET || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic void put(input logic [1:0] mode, input logic [7:0] c);
    framer_req_t r;
    r.mode = mode;
    r.ch   = c;
    req_q.push_back(r);
  endfunction

  // A well-formed message with random nesting, strings, escapes and filler.
  function automatic void add_message(input int steps);
    bit kinds [$];
    bit kind;
    repeat ($urandom_range(0, 2)) put(MODE_CHAR, blank_char());
    kind = 1'($urandom_range(0, 1));
    kinds.push_back(kind);
    put(MODE_CHAR, opener_for(kind));
    repeat (steps) begin
      case ($urandom_range(0, 5))
        0: if (kinds.size() < 6) begin
          kind = 1'($urandom_range(0, 1));
          kinds.push_back(kind);
          put(MODE_CHAR, opener_for(kind));
        end
        1: if (kinds.size() > 1) put(MODE_CHAR, closer_for(kinds.pop_back()));
        2: begin
          put(MODE_CHAR, CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
              put(MODE_CHAR, CH_BSLASH);
              put(MODE_CHAR, 8'($urandom_range(0, 255)));
            end else begin
              put(MODE_CHAR, text_char());
            end
          end
          put(MODE_CHAR, CH_QUOTE);
        end
        default: put(MODE_CHAR, filler_char());
      endcase
    end
    while (kinds.size() > 0) put(MODE_CHAR, closer_for(kinds.pop_back()));
  endfunction

  // More openers than the stack holds end the message as an error.
  function automatic void add_deep_nest(input int n);
    bit kinds [$];
    bit kind;
    repeat (n) begin
      kind = 1'($urandom_range(0, 1));
      kinds.push_back(kind);
      put(MODE_CHAR, opener_for(kind));
    end
    while (kinds.size() > 0) put(MODE_CHAR, closer_for(kinds.pop_back()));
  endfunction

  function automatic void build_sequence();
    int sel;
    int start;
    logic [1:0] mode;
    sel = $urandom_range(0, 99);
    start = req_q.size();
    if (sel < 60) begin
      add_message($urandom_range(1, 14));
    end else if (sel < 75) begin
      // Replace one byte of an otherwise sound message with a random special byte.
      add_message($urandom_range(2, 12));
      req_q[$urandom_range(start, req_q.size() - 1)].ch = special_char();
    end else if (sel < 86) begin
      add_message($urandom_range(2, 12));
      repeat ($urandom_range(1, 4)) if (req_q.size() > start) void'(req_q.pop_back());
      put($urandom_range(0, 1) ? MODE_FLUSH : MODE_DISCARD, 8'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      repeat ($urandom_range(1, 6)) begin
        mode = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : MODE_CHAR;
        put(mode, $urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
      end
    end else begin
      add_deep_nest($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6));
    end
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [7:0] c, input bit typed,
                           input bit typed_has, input frame_res_t typed_res);
    frame_res_t res;
    bit has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    char_in_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    has = frame_step(mode, c, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) frame_q.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void report_miss(input string what, input frame_res_t want);
    if (fail_count < MAX_REPORTS)
      $display("%0t: %s: got char=%h valid=%b last=%b end=%0d, wanted char=%h valid=%b last=%b end=%0d",
               $time, what, char_out_o, char_valid_o, last_o, end_kind_o,
               want.ch, want.ch_valid, want.last, want.kind);
    fail_count++;
  endfunction

  // Result side: checks each accepted result and drives the stall.
  always @(posedge clk_i) begin : result_side
    frame_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        report_miss("result with no request pending", NO_RES);
      end else begin
        want = frame_q.pop_front();
        if (char_out_o !== want.ch || char_valid_o !== want.ch_valid ||
            last_o !== want.last || end_kind_o !== want.kind)
          report_miss("mismatch", want);
      end
    end
    if (holds_done < holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    framer_req_t r;
    int sent;
    framer_clear();
    send_idle_pct  = 17;
    recv_stall_pct = 49;
    holds_asked    = 0;
    holds_done     = 0;
    hold_left      = 0;
    fail_count     = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED[i].mode, DIRECTED[i].ch, DIRECTED[i].typed,
                DIRECTED[i].has_res, DIRECTED[i].res);

    for (int p = 0; p < 3; p++) begin
      // The sender waits for every outstanding result before the idling pattern changes.
      wait_drained();
      case (p)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (p != 1) holds_asked++;
      sent = 0;
      add_deep_nest(STACK_DEPTH + 1);
      while (sent < PHASE_ITEMS) begin
        if (req_q.size() == 0) build_sequence();
        r = req_q.pop_front();
        send_item(r.mode, r.ch, 1'b0, 1'b0, NO_RES);
        if (r.mode != MODE_UNKNOWN) sent++;
      end
      req_q.delete();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && frame_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
